// File: sv/fscd_pkg.sv
`timescale 1ns / 1ps
// fscd_pkg: shared types, widths, register codes and reset values of the
// flex sensor click detector; used by every module of the block but fscd_div

package fscd_pkg;

    // converter and fixed point layout
    localparam int ADC_BITS      = 12;
    localparam int FRAC_BITS     = 8;
    localparam int FILT_W        = ADC_BITS + FRAC_BITS;
    localparam int MAX_CALIB_DEF = 1024;
    localparam logic [ADC_BITS-1:0] ADC_MAX = {ADC_BITS{1'b1}};

    // register field widths
    localparam int ALPHA_W  = 9;
    localparam int MARGIN_W = 12;
    localparam int DEB_W    = 8;
    localparam int CALN_W   = 11;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_MARGIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_MARGIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_SAMPLES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIB_SAMPLES    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIB_MAX_RANGE  = 3'd5;

    // register reset values
    localparam logic [ALPHA_W-1:0]  RST_FILTER_ALPHA     = 9'd64;
    localparam logic [MARGIN_W-1:0] RST_PRESS_MARGIN     = 12'd300;
    localparam logic [MARGIN_W-1:0] RST_RELEASE_MARGIN   = 12'd150;
    localparam logic [DEB_W-1:0]    RST_DEBOUNCE_SAMPLES = 8'd3;
    localparam logic [CALN_W-1:0]   RST_CALIB_SAMPLES    = 11'd64;
    localparam logic [MARGIN_W-1:0] RST_CALIB_MAX_RANGE  = 12'd200;

    // item classes decided by the front
    typedef logic t_op;
    localparam t_op OP_CALIB = 1'b0;
    localparam t_op OP_RUN   = 1'b1;

    typedef struct packed {
        logic                mode;
        logic [ADC_BITS-1:0] index_sample;
        logic [ADC_BITS-1:0] middle_sample;
    } t_in;

    typedef struct packed {
        logic                left_pressed;
        logic                right_pressed;
        logic                calib_done;
        logic                index_connected;
        logic                middle_connected;
        logic [ADC_BITS-1:0] index_baseline;
        logic [ADC_BITS-1:0] middle_baseline;
        logic [ADC_BITS-1:0] index_level;
        logic [ADC_BITS-1:0] middle_level;
    } t_out;

    typedef struct packed {
        logic [ALPHA_W-1:0]  filter_alpha;
        logic [MARGIN_W-1:0] press_margin;
        logic [MARGIN_W-1:0] release_margin;
        logic [DEB_W-1:0]    debounce_samples;
        logic [CALN_W-1:0]   calib_samples;
        logic [MARGIN_W-1:0] calib_max_range;
    } t_cfg;

    typedef struct packed {
        t_op                 op;
        logic [ADC_BITS-1:0] index_sample;
        logic [ADC_BITS-1:0] middle_sample;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

endpackage

// File: sv/fscd_front.sv
`timescale 1ns / 1ps
// fscd_front: input side of the detector, classifies each request and
// holds it in a two entry queue for the back end; uses fscd_pkg

module fscd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  fscd_pkg::t_in   i_in,
    output fscd_pkg::t_qhead o_head,
    input  logic            i_pop
);
    import fscd_pkg::*;

    localparam int Q_DEPTH = 2;

    t_item      r_slot [Q_DEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    t_item      w_item;

    assign o_in_stall = (r_cnt == 2'(Q_DEPTH));
    assign w_push     = i_in_valid && !o_in_stall;

    always_comb begin
        w_item.op            = i_in.mode ? OP_RUN : OP_CALIB;
        w_item.index_sample  = i_in.index_sample;
        w_item.middle_sample = i_in.middle_sample;
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: sv/fscd_div.sv
`timescale 1ns / 1ps
// fscd_div: restoring divider, one quotient bit per cycle, for the
// calibration baseline average; no package dependencies

module fscd_div #(
    parameter int DVD_W = 22,
    parameter int DVS_W = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot
);
    localparam int CW = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   w_sh;
    logic [DVS_W:0]   w_diff;
    logic [DVS_W-1:0] n_rem;
    logic [DVD_W-1:0] n_quo;

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
        w_sh   = {r_rem, r_quo[DVD_W-1]};
        w_diff = w_sh - {1'b0, r_dvs};
        if (w_sh >= {1'b0, r_dvs}) begin
            n_rem = w_diff[DVS_W-1:0];
            n_quo = {r_quo[DVD_W-2:0], 1'b1};
        end else begin
            n_rem = w_sh[DVS_W-1:0];
            n_quo = {r_quo[DVD_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

endmodule

// File: sv/fscd_core.sv
`timescale 1ns / 1ps
// fscd_core: back end of the detector, calibration, filter, hysteresis,
// debounce and the result register; uses fscd_pkg and fscd_div

module fscd_core #(
    parameter int MAX_CALIB = fscd_pkg::MAX_CALIB_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fscd_pkg::t_cfg   i_cfg,
    input  fscd_pkg::t_qhead i_head,
    output logic             o_pop,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output fscd_pkg::t_out   o_out
);
    import fscd_pkg::*;

    localparam int CNT_W  = $clog2(MAX_CALIB + 1);
    localparam int SUM_W  = ADC_BITS + CNT_W;
    localparam int PROD_W = FILT_W + ALPHA_W + 2;
    localparam int PAD_W  = PROD_W - FILT_W - FRAC_BITS;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CAL     = 3'd1;
    localparam logic [2:0] ST_DIVGO   = 3'd2;
    localparam logic [2:0] ST_DIVWAIT = 3'd3;
    localparam logic [2:0] ST_MUL     = 3'd4;
    localparam logic [2:0] ST_ACC     = 3'd5;
    localparam logic [2:0] ST_HYS     = 3'd6;
    localparam logic [2:0] ST_EMIT    = 3'd7;

    // per sensor state, lane 0 index, lane 1 middle
    logic [FILT_W-1:0]   r_filt    [2];
    logic [ADC_BITS-1:0] r_base    [2];
    logic                r_present [2];
    logic                r_press   [2];
    logic                r_cand    [2];
    logic [DEB_W-1:0]    r_agree   [2];
    logic [SUM_W-1:0]    r_sum     [2];
    logic [ADC_BITS-1:0] r_low     [2];
    logic [ADC_BITS-1:0] r_high    [2];
    logic [ADC_BITS-1:0] r_samp    [2];
    logic [CNT_W-1:0]    r_count;
    logic                r_running;
    logic                r_valid;

    logic [2:0]               r_state;
    logic                     r_sel;
    logic                     r_run;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_out_valid;
    t_out                     r_out;

    logic [31:0]              w_n32;
    logic [CNT_W-1:0]         w_n;
    logic [ALPHA_W-1:0]       w_alpha;
    logic [DEB_W-1:0]         w_db;
    logic [SUM_W-1:0]         w_sum_nx  [2];
    logic [ADC_BITS-1:0]      w_low_nx  [2];
    logic [ADC_BITS-1:0]      w_high_nx [2];
    logic [CNT_W-1:0]         w_cnt_nx;
    logic signed [ALPHA_W:0]  w_alpha_s;
    logic signed [FILT_W:0]   w_diff;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_acc;
    logic [FILT_W-1:0]        w_fnew;
    logic [ADC_BITS-1:0]      w_lvl;
    logic signed [ADC_BITS:0] w_lvl_s;
    logic signed [ADC_BITS:0] w_thp;
    logic signed [ADC_BITS:0] w_thr;
    logic                     w_dec;
    logic                     n_cand;
    logic [DEB_W-1:0]         n_agree;
    logic                     n_press;
    logic                     w_slot;
    logic                     w_div_go;
    logic                     w_div_done;
    logic [SUM_W-1:0]         w_quot;
    t_out                     w_out;

    // register values with their out of range codes folded in
    always_comb begin
        if (i_cfg.calib_samples == '0) begin
            w_n32 = 32'd1;
        end else if (32'(i_cfg.calib_samples) > 32'(MAX_CALIB)) begin
            w_n32 = 32'(MAX_CALIB);
        end else begin
            w_n32 = 32'(i_cfg.calib_samples);
        end
    end
    assign w_n     = w_n32[CNT_W-1:0];
    assign w_alpha = (i_cfg.filter_alpha > ALPHA_ONE) ? ALPHA_ONE : i_cfg.filter_alpha;
    assign w_db    = (i_cfg.debounce_samples == '0) ? DEB_W'(1) : i_cfg.debounce_samples;

    // calibration accumulate, a fresh run starts from cleared sums
    always_comb begin
        for (int s = 0; s < 2; s++) begin
            w_sum_nx[s]  = (r_running ? r_sum[s] : '0) + SUM_W'(r_samp[s]);
            w_low_nx[s]  = r_running ? r_low[s] : ADC_MAX;
            w_high_nx[s] = r_running ? r_high[s] : '0;
            if (r_samp[s] < w_low_nx[s]) begin
                w_low_nx[s] = r_samp[s];
            end
            if (r_samp[s] > w_high_nx[s]) begin
                w_high_nx[s] = r_samp[s];
            end
        end
    end
    assign w_cnt_nx = (r_running ? r_count : '0) + CNT_W'(1);

    // filter: f + alpha * (s - f) / 256, one product then one add
    assign w_alpha_s = $signed({1'b0, w_alpha});
    assign w_diff    = $signed({1'b0, r_samp[r_sel], {FRAC_BITS{1'b0}}})
                     - $signed({1'b0, r_filt[r_sel]});
    assign w_prod    = w_alpha_s * w_diff;
    assign w_acc     = r_prod + $signed({{PAD_W{1'b0}}, r_filt[r_sel], {FRAC_BITS{1'b0}}});
    assign w_fnew    = w_acc[FILT_W+FRAC_BITS-1:FRAC_BITS];

    // hysteresis below the baseline, thresholds may go negative
    assign w_lvl   = r_filt[r_sel][FILT_W-1:FRAC_BITS];
    assign w_lvl_s = $signed({1'b0, w_lvl});
    assign w_thp   = $signed({1'b0, r_base[r_sel]}) - $signed({1'b0, i_cfg.press_margin});
    assign w_thr   = $signed({1'b0, r_base[r_sel]}) - $signed({1'b0, i_cfg.release_margin});

    always_comb begin
        w_dec = r_press[r_sel];
        if (!r_press[r_sel] && (w_lvl_s <= w_thp)) begin
            w_dec = 1'b1;
        end else if (r_press[r_sel] && (w_lvl_s >= w_thr)) begin
            w_dec = 1'b0;
        end
        if (w_dec == r_cand[r_sel]) begin
            n_cand  = r_cand[r_sel];
            n_agree = (r_agree[r_sel] < w_db) ? r_agree[r_sel] + DEB_W'(1) : r_agree[r_sel];
        end else begin
            n_cand  = w_dec;
            n_agree = DEB_W'(1);
        end
        n_press = (n_agree >= w_db) ? n_cand : r_press[r_sel];
    end

    // shared divider, index sum first, then middle sum
    assign w_div_go = (r_state == ST_DIVGO);

    fscd_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_go),
        .i_dividend (r_sum[r_sel]),
        .i_divisor  (w_n),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_comb begin
        w_out.left_pressed     = r_run && r_valid && r_present[0] && r_press[0];
        w_out.right_pressed    = r_run && r_valid && r_present[1] && r_press[1];
        w_out.calib_done       = r_valid;
        w_out.index_connected  = r_present[0];
        w_out.middle_connected = r_present[1];
        w_out.index_baseline   = r_base[0];
        w_out.middle_baseline  = r_base[1];
        w_out.index_level      = r_filt[0][FILT_W-1:FRAC_BITS];
        w_out.middle_level     = r_filt[1][FILT_W-1:FRAC_BITS];
    end

    assign w_slot      = !r_out_valid || !i_out_stall;
    assign o_pop       = (r_state == ST_IDLE) && i_head.valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 2; s++) begin
                r_filt[s]    <= '0;
                r_base[s]    <= '0;
                r_present[s] <= 1'b0;
                r_press[s]   <= 1'b0;
                r_cand[s]    <= 1'b0;
                r_agree[s]   <= '0;
                r_sum[s]     <= '0;
                r_low[s]     <= ADC_MAX;
                r_high[s]    <= '0;
            end
            r_count     <= '0;
            r_running   <= 1'b0;
            r_valid     <= 1'b0;
            r_state     <= ST_IDLE;
            r_sel       <= 1'b0;
            r_run       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_head.valid) begin
                        r_samp[0] <= i_head.item.index_sample;
                        r_samp[1] <= i_head.item.middle_sample;
                        r_sel     <= 1'b0;
                        r_run     <= (i_head.item.op == OP_RUN);
                        if (i_head.item.op == OP_CALIB) begin
                            r_state <= ST_CAL;
                        end else begin
                            // a run sample abandons any calibration in progress
                            r_running <= 1'b0;
                            r_state   <= r_valid ? ST_MUL : ST_EMIT;
                        end
                    end
                end
                ST_CAL: begin
                    for (int s = 0; s < 2; s++) begin
                        r_sum[s]  <= w_sum_nx[s];
                        r_low[s]  <= w_low_nx[s];
                        r_high[s] <= w_high_nx[s];
                    end
                    if (!r_running) begin
                        r_valid      <= 1'b0;
                        r_present[0] <= 1'b0;
                        r_present[1] <= 1'b0;
                    end
                    r_count   <= w_cnt_nx;
                    r_running <= 1'b1;
                    r_state   <= (w_cnt_nx >= w_n) ? ST_DIVGO : ST_EMIT;
                end
                ST_DIVGO: begin
                    r_state <= ST_DIVWAIT;
                end
                ST_DIVWAIT: begin
                    if (w_div_done) begin
                        r_base[r_sel] <= w_quot[ADC_BITS-1:0];
                        r_filt[r_sel] <= {w_quot[ADC_BITS-1:0], {FRAC_BITS{1'b0}}};
                        if (!r_sel) begin
                            r_sel   <= 1'b1;
                            r_state <= ST_DIVGO;
                        end else begin
                            for (int s = 0; s < 2; s++) begin
                                r_present[s] <= ((r_high[s] - r_low[s]) <= i_cfg.calib_max_range);
                            end
                            r_valid   <= 1'b1;
                            r_running <= 1'b0;
                            r_state   <= ST_EMIT;
                        end
                    end
                end
                ST_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    r_filt[r_sel] <= w_fnew;
                    if (r_present[r_sel]) begin
                        r_state <= ST_HYS;
                    end else if (!r_sel) begin
                        r_sel   <= 1'b1;
                        r_state <= ST_MUL;
                    end else begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_HYS: begin
                    r_cand[r_sel]  <= n_cand;
                    r_agree[r_sel] <= n_agree;
                    r_press[r_sel] <= n_press;
                    if (!r_sel) begin
                        r_sel   <= 1'b1;
                        r_state <= ST_MUL;
                    end else begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_slot) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_EMIT) && w_slot) begin
            r_out <= w_out;
        end
    end

endmodule

// File: sv/flex_sensor_click_detector.sv
`timescale 1ns / 1ps
// flex_sensor_click_detector: top level, configuration registers, front
// queue and back end; uses fscd_pkg, fscd_front, fscd_core (fscd_div)
//
//  channel   direction  handshake                    payload
//  in        sink       i_in_valid / o_in_stall      fscd_pkg::t_in   i_in
//  out       source     o_out_valid / i_out_stall    fscd_pkg::t_out  o_out
//  cfg       sink       i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
//  a run request passes through pick up, then per sensor multiply, accumulate and
//  hysteresis (the last one skipped for an unconnected sensor), then result load;
//  only pick up and result load while no calibration is valid
//  a calibration request passes through pick up, accumulate and result load; the one
//  that closes calibration adds the index then the middle average in the shared one
//  bit per cycle divider, SUM_W = 12 + clog2(MAX_CALIB + 1) bits wide
//  reset is synchronous, active low, no clearing pass, ready the next cycle;
//  the two entry queue keeps taking requests while a result waits on stall, until it is full

module flex_sensor_click_detector #(
    parameter int MAX_CALIB = fscd_pkg::MAX_CALIB_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  fscd_pkg::t_in                     i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output fscd_pkg::t_out                    o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fscd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fscd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import fscd_pkg::*;

    t_cfg   r_cfg;
    t_qhead w_head;
    logic   w_pop;

    // registers are always writable; writes must only come while idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_alpha     <= RST_FILTER_ALPHA;
            r_cfg.press_margin     <= RST_PRESS_MARGIN;
            r_cfg.release_margin   <= RST_RELEASE_MARGIN;
            r_cfg.debounce_samples <= RST_DEBOUNCE_SAMPLES;
            r_cfg.calib_samples    <= RST_CALIB_SAMPLES;
            r_cfg.calib_max_range  <= RST_CALIB_MAX_RANGE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FILTER_ALPHA: begin
                    r_cfg.filter_alpha <= i_cfg_data[ALPHA_W-1:0];
                end
                CFG_PRESS_MARGIN: begin
                    r_cfg.press_margin <= i_cfg_data[MARGIN_W-1:0];
                end
                CFG_RELEASE_MARGIN: begin
                    r_cfg.release_margin <= i_cfg_data[MARGIN_W-1:0];
                end
                CFG_DEBOUNCE_SAMPLES: begin
                    r_cfg.debounce_samples <= i_cfg_data[DEB_W-1:0];
                end
                CFG_CALIB_SAMPLES: begin
                    r_cfg.calib_samples <= i_cfg_data[CALN_W-1:0];
                end
                CFG_CALIB_MAX_RANGE: begin
                    r_cfg.calib_max_range <= i_cfg_data[MARGIN_W-1:0];
                end
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // front: classify and queue
    fscd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_head     (w_head),
        .i_pop      (w_pop)
    );

    // back: calibration, filter, press logic, result register
    fscd_core #(
        .MAX_CALIB (MAX_CALIB)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

// File: sv/fscd_chk.sv
`timescale 1ns / 1ps
// fscd_chk: port level checks of the click detector, bound to the top
// level below; uses fscd_pkg

module fscd_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input fscd_pkg::t_in                   i_in,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input fscd_pkg::t_out                  o_out,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [fscd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [fscd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // a left press needs a finished calibration and a connected index sensor
    a_left_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.left_pressed |-> o_out.calib_done && o_out.index_connected)
        else $error("left press without valid calibration");

    // same for the middle sensor
    a_right_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.right_pressed |-> o_out.calib_done && o_out.middle_connected)
        else $error("right press without valid calibration");

    // reset clears the result valid and leaves the request side unstalled
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("not empty after reset");

endmodule

bind flex_sensor_click_detector fscd_chk u_fscd_chk (.*);

// File: dv/fscd_checker.sv
`timescale 1ns / 1ps
// fscd_checker: watches the request, result and register channels of the
// flex sensor click detector, predicts every result and compares it
// depends on fscd_pkg only

module fscd_checker #(
    parameter int MAX_CALIB = fscd_pkg::MAX_CALIB_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  fscd_pkg::t_in                   i_in,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  fscd_pkg::t_out                  i_out,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [fscd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fscd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_checked,
    output int                              o_button_down,
    output int                              o_calib_closes
);
    import fscd_pkg::*;

    // register copy and per finger state
    t_cfg                regs;
    logic [FILT_W-1:0]   filt [2];
    logic [ADC_BITS-1:0] baseline [2];
    logic                present [2];
    logic                held [2];
    logic                cand [2];
    logic [DEB_W-1:0]    agree [2];
    logic [21:0]         cal_sum [2];
    logic [ADC_BITS-1:0] cal_lo [2];
    logic [ADC_BITS-1:0] cal_hi [2];
    logic [CALN_W-1:0]   cal_cnt;
    logic                cal_running;
    logic                cal_valid;

    t_out pending_reports [$];
    t_out oldest;
    int   fails    = 0;
    int   compared = 0;
    int   downs    = 0;
    int   closes   = 0;

    task automatic report_mismatch(input string what);
        fails++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [ADC_BITS-1:0] got,
                               input logic [ADC_BITS-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                      compared, name, got, want));
    endtask

    // filter, hysteresis and debounce of one finger for one run sample
    function automatic void step_finger(int s, logic [ADC_BITS-1:0] raw);
        longint unsigned wt;
        longint unsigned acc;
        int              db;
        int              level;
        int              press_th;
        int              rel_th;
        logic            decision;
        wt  = (regs.filter_alpha > ALPHA_ONE) ? ALPHA_ONE : regs.filter_alpha;
        db  = (regs.debounce_samples == 0) ? 1 : regs.debounce_samples;
        acc = wt * (longint'(raw) << FRAC_BITS) + (256 - wt) * filt[s];
        filt[s] = FILT_W'(acc >> FRAC_BITS);
        // unconnected finger: filter moves, buttons frozen
        if (!present[s]) return;
        level    = int'(filt[s] >> FRAC_BITS);
        press_th = int'(baseline[s]) - int'(regs.press_margin);
        rel_th   = int'(baseline[s]) - int'(regs.release_margin);
        decision = held[s];
        if (!held[s] && level <= press_th) decision = 1'b1;
        else if (held[s] && level >= rel_th) decision = 1'b0;
        if (decision == cand[s]) begin
            if (agree[s] < db) agree[s] = agree[s] + 1'b1;
        end else begin
            cand[s]  = decision;
            agree[s] = DEB_W'(1);
        end
        if (agree[s] >= db) held[s] = cand[s];
    endfunction

    function automatic t_out predict_report(t_in req);
        t_out                rep;
        int                  n;
        logic [ADC_BITS-1:0] raw [2];
        raw[0] = req.index_sample;
        raw[1] = req.middle_sample;
        rep    = '0;
        if (req.mode == OP_CALIB) begin
            n = (regs.calib_samples == 0) ? 1 : regs.calib_samples;
            if (n > MAX_CALIB) n = MAX_CALIB;
            // fresh calibration: sums cleared, baselines kept until it closes
            if (!cal_running) begin
                for (int s = 0; s < 2; s++) begin
                    cal_sum[s] = '0;
                    cal_lo[s]  = ADC_MAX;
                    cal_hi[s]  = '0;
                    present[s] = 1'b0;
                end
                cal_cnt     = '0;
                cal_valid   = 1'b0;
                cal_running = 1'b1;
            end
            for (int s = 0; s < 2; s++) begin
                cal_sum[s] = cal_sum[s] + raw[s];
                if (raw[s] < cal_lo[s]) cal_lo[s] = raw[s];
                if (raw[s] > cal_hi[s]) cal_hi[s] = raw[s];
            end
            cal_cnt = cal_cnt + 1'b1;
            if (cal_cnt >= n) begin
                for (int s = 0; s < 2; s++) begin
                    baseline[s] = ADC_BITS'(cal_sum[s] / n);
                    filt[s]     = FILT_W'(baseline[s]) << FRAC_BITS;
                    present[s]  = (cal_hi[s] - cal_lo[s]) <= regs.calib_max_range;
                end
                cal_valid   = 1'b1;
                cal_running = 1'b0;
                closes++;
            end
        end else begin
            cal_running = 1'b0;
            if (cal_valid) begin
                step_finger(0, raw[0]);
                step_finger(1, raw[1]);
            end
            rep.left_pressed  = cal_valid & present[0] & held[0];
            rep.right_pressed = cal_valid & present[1] & held[1];
        end
        rep.calib_done       = cal_valid;
        rep.index_connected  = present[0];
        rep.middle_connected = present[1];
        rep.index_baseline   = baseline[0];
        rep.middle_baseline  = baseline[1];
        rep.index_level      = filt[0][FILT_W-1:FRAC_BITS];
        rep.middle_level     = filt[1][FILT_W-1:FRAC_BITS];
        return rep;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.filter_alpha     = RST_FILTER_ALPHA;
            regs.press_margin     = RST_PRESS_MARGIN;
            regs.release_margin   = RST_RELEASE_MARGIN;
            regs.debounce_samples = RST_DEBOUNCE_SAMPLES;
            regs.calib_samples    = RST_CALIB_SAMPLES;
            regs.calib_max_range  = RST_CALIB_MAX_RANGE;
            for (int s = 0; s < 2; s++) begin
                filt[s]     = '0;
                baseline[s] = '0;
                present[s]  = 1'b0;
                held[s]     = 1'b0;
                cand[s]     = 1'b0;
                agree[s]    = '0;
                cal_sum[s]  = '0;
                cal_lo[s]   = ADC_MAX;
                cal_hi[s]   = '0;
            end
            cal_cnt     = '0;
            cal_running = 1'b0;
            cal_valid   = 1'b0;
            pending_reports.delete();
        end else begin
            // results first: a result never belongs to a request of the same edge
            if (i_out_valid && !i_out_stall) begin
                if (pending_reports.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    oldest = pending_reports.pop_front();
                    check_field("left_pressed", i_out.left_pressed, oldest.left_pressed);
                    check_field("right_pressed", i_out.right_pressed, oldest.right_pressed);
                    check_field("calib_done", i_out.calib_done, oldest.calib_done);
                    check_field("index_connected", i_out.index_connected,
                                oldest.index_connected);
                    check_field("middle_connected", i_out.middle_connected,
                                oldest.middle_connected);
                    check_field("index_baseline", i_out.index_baseline,
                                oldest.index_baseline);
                    check_field("middle_baseline", i_out.middle_baseline,
                                oldest.middle_baseline);
                    check_field("index_level", i_out.index_level, oldest.index_level);
                    check_field("middle_level", i_out.middle_level, oldest.middle_level);
                    compared++;
                    if (oldest.left_pressed || oldest.right_pressed) downs++;
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FILTER_ALPHA:     regs.filter_alpha     = i_cfg_data[ALPHA_W-1:0];
                    CFG_PRESS_MARGIN:     regs.press_margin     = i_cfg_data[MARGIN_W-1:0];
                    CFG_RELEASE_MARGIN:   regs.release_margin   = i_cfg_data[MARGIN_W-1:0];
                    CFG_DEBOUNCE_SAMPLES: regs.debounce_samples = i_cfg_data[DEB_W-1:0];
                    CFG_CALIB_SAMPLES:    regs.calib_samples    = i_cfg_data[CALN_W-1:0];
                    CFG_CALIB_MAX_RANGE:  regs.calib_max_range  = i_cfg_data[MARGIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) pending_reports.push_back(predict_report(i_in));
        end
        o_fail_count   <= fails;
        o_pending      <= pending_reports.size();
        o_checked      <= compared;
        o_button_down  <= downs;
        o_calib_closes <= closes;
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// testbench: top of the click detector bench; drives requests, register
// loads and output stalls, and gives the verdict
// depends on fscd_pkg, flex_sensor_click_detector and fscd_checker

module testbench;
    import fscd_pkg::*;

    localparam int IDLE_LIMIT  = 5000;  // cycles without any handshake
    localparam int RANDOM_REQS = 800;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in                   in_req    = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out                  out_rep;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int checked;
    int button_down;
    int calib_closes;

    // idling of the two sides, in percent of cycles
    int src_idle_pct   = 32;
    int sink_stall_pct = 52;
    int reqs_sent      = 0;
    int reg_loads      = 0;
    int idle_cycles    = 0;

    always #5 clk = ~clk;

    flex_sensor_click_detector u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_rep),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    fscd_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in           (in_req),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out          (out_rep),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_button_down  (button_down),
        .o_calib_closes (calib_closes)
    );

    // result side: random stall per cycle, independent of valid
    always @(posedge clk) begin
        if (!rst_n) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end

    // watchdog: any accepted request, result or register write restarts it
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake in %0d cycles", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // builds a request, clipping both samples into the converter range
    function automatic t_in mk_req(t_op op, int idx, int mid);
        t_in r;
        r.mode          = op;
        r.index_sample  = (idx < 0) ? '0 : (idx > int'(ADC_MAX)) ? ADC_MAX : ADC_BITS'(idx);
        r.middle_sample = (mid < 0) ? '0 : (mid > int'(ADC_MAX)) ? ADC_MAX : ADC_BITS'(mid);
        return r;
    endfunction

    // symmetric noise of at most amp counts
    function automatic int wobble(int amp);
        return int'($urandom_range(0, 2 * amp)) - amp;
    endfunction

    // called right after an edge; returns at the edge that takes the request,
    // valid stays high so a following call can go back to back
    task automatic send_req(input t_in req);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        reqs_sent++;
    endtask

    // waits until every request has its result, plus a short margin
    task automatic wait_drained();
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    // writes all six registers once the block has gone idle
    task automatic load_settings(input int alpha, input int press, input int rel,
                                 input int deb, input int cal, input int span);
        logic [CFG_DATA_W-1:0] vals [6];
        vals[CFG_FILTER_ALPHA]     = CFG_DATA_W'(alpha);
        vals[CFG_PRESS_MARGIN]     = CFG_DATA_W'(press);
        vals[CFG_RELEASE_MARGIN]   = CFG_DATA_W'(rel);
        vals[CFG_DEBOUNCE_SAMPLES] = CFG_DATA_W'(deb);
        vals[CFG_CALIB_SAMPLES]    = CFG_DATA_W'(cal);
        vals[CFG_CALIB_MAX_RANGE]  = CFG_DATA_W'(span);
        in_valid <= 1'b0;
        wait_drained();
        for (int r = CFG_FILTER_ALPHA; r <= CFG_CALIB_MAX_RANGE; r++) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(r);
            cfg_data  <= vals[r];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
        reg_loads++;
    endtask

    // one random setting, a calibration (sometimes abandoned first) and a
    // few press gestures with noise on both fingers
    task automatic play_episode();
        int alpha;
        int press;
        int rel;
        int deb;
        int cal;
        int span;
        int n;
        int jit;
        int base_i;
        int base_m;
        int down_i;
        int down_m;
        case ($urandom_range(0, 9))
            0:       alpha = 0;
            1:       alpha = $urandom_range(257, 511);  // clamps to one
            2:       alpha = 256;
            default: alpha = $urandom_range(32, 255);
        endcase
        case ($urandom_range(0, 9))
            0:       press = 0;
            1:       press = 4095;
            default: press = $urandom_range(50, 600);
        endcase
        case ($urandom_range(0, 9))
            0:       rel = 0;
            1:       rel = 4095;
            default: rel = $urandom_range(0, press);
        endcase
        case ($urandom_range(0, 9))
            0:       deb = 0;
            1:       deb = 255;
            default: deb = $urandom_range(1, 5);
        endcase
        case ($urandom_range(0, 9))
            0:       cal = 0;
            1:       cal = $urandom_range(16, 64);
            default: cal = $urandom_range(1, 8);
        endcase
        case ($urandom_range(0, 9))
            0:       span = 0;
            1:       span = 4095;
            default: span = $urandom_range(20, 400);
        endcase
        n      = (cal == 0) ? 1 : cal;
        jit    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 150);
        base_i = $urandom_range(0, 4095);
        base_m = $urandom_range(0, 4095);
        load_settings(alpha, press, rel, deb, cal, span);

        // abandoned calibration: a run sample cuts it short
        if (n > 1 && $urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, n - 1))
                send_req(mk_req(OP_CALIB, base_i + wobble(jit), base_m + wobble(jit)));
            send_req(mk_req(OP_RUN, $urandom_range(0, 4095), $urandom_range(0, 4095)));
        end
        repeat (n)
            send_req(mk_req(OP_CALIB, base_i + wobble(jit), base_m + wobble(jit)));

        repeat ($urandom_range(1, 4)) begin
            down_i = $urandom_range(0, 1) ? press + $urandom_range(0, 600) : 0;
            down_m = $urandom_range(0, 1) ? press + $urandom_range(0, 600) : 0;
            // finger bent
            repeat ($urandom_range(1, 12))
                send_req(mk_req(OP_RUN, base_i - down_i + wobble(jit),
                                base_m - down_m + wobble(jit)));
            // finger straight again
            repeat ($urandom_range(1, 10))
                send_req(mk_req(OP_RUN, base_i + wobble(jit), base_m + wobble(jit)));
            // stray request, a calibration one restarts calibration mid run
            if ($urandom_range(0, 9) == 0)
                send_req(mk_req(t_op'($urandom_range(0, 1)), $urandom_range(0, 4095),
                                $urandom_range(0, 4095)));
        end
    endtask

    initial begin
        int directed_reqs;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // run samples before any calibration: buttons stay up, nothing moves
        send_req(mk_req(OP_RUN, 4095, 0));
        send_req(mk_req(OP_RUN, 0, 4095));

        // two sample calibration, middle finger swings too far
        load_settings(256, 300, 150, 1, 2, 100);
        send_req(mk_req(OP_CALIB, 2000, 1000));
        send_req(mk_req(OP_CALIB, 2010, 1400));
        // full weight filter: press then release on the index finger
        send_req(mk_req(OP_RUN, 0, 0));
        send_req(mk_req(OP_RUN, 4095, 4095));
        // new calibration after run samples, abandoned by a run sample
        send_req(mk_req(OP_CALIB, 100, 100));
        send_req(mk_req(OP_RUN, 50, 50));
        send_req(mk_req(OP_CALIB, 4095, 4095));
        send_req(mk_req(OP_CALIB, 4095, 4095));
        send_req(mk_req(OP_RUN, 0, 0));
        send_req(mk_req(OP_RUN, 0, 0));

        // alpha above one, zero debounce, zero count, margins at the ends:
        // the middle threshold lands below zero so it can never press
        load_settings(511, 4095, 0, 0, 0, 4095);
        send_req(mk_req(OP_CALIB, 4095, 0));
        send_req(mk_req(OP_RUN, 0, 0));
        send_req(mk_req(OP_RUN, 4095, 4095));
        // calibration right after a completed one
        send_req(mk_req(OP_CALIB, 0, 0));

        // frozen filter, longest debounce, no swing allowed
        load_settings(0, 0, 4095, 255, 3, 0);
        send_req(mk_req(OP_CALIB, 1234, 1234));
        send_req(mk_req(OP_CALIB, 1234, 1234));
        send_req(mk_req(OP_CALIB, 1234, 1235));
        send_req(mk_req(OP_RUN, 0, 4095));
        send_req(mk_req(OP_RUN, 4095, 0));
        directed_reqs = reqs_sent;

        // random episodes: receiver mostly stalling, then sender mostly idle, then neither
        while (reqs_sent - directed_reqs < RANDOM_REQS) begin
            if (reqs_sent - directed_reqs < RANDOM_REQS / 3) begin
                src_idle_pct   <= 32;
                sink_stall_pct <= 52;
            end else if (reqs_sent - directed_reqs < 2 * RANDOM_REQS / 3) begin
                src_idle_pct   <= 52;
                sink_stall_pct <= 32;
            end else begin
                src_idle_pct   <= 0;
                sink_stall_pct <= 0;
            end
            play_episode();
        end

        // count above the maximum clamps to it: one full length calibration
        // with the middle finger pinned high drives the sum to its largest reachable value
        load_settings(128, 200, 100, 2, 1500, 4095);
        repeat (MAX_CALIB_DEF)
            send_req(mk_req(OP_CALIB, $urandom_range(0, 4095), 4095));
        repeat (24)
            send_req(mk_req(OP_RUN, $urandom_range(0, 4095), $urandom_range(0, 4095)));

        in_valid <= 1'b0;
        wait_drained();
        // room for the divider to show any stray result
        repeat (200) @(posedge clk);

        $display("run covered %0d requests over %0d register loads, %0d calibrations closed",
                 reqs_sent, reg_loads, calib_closes);
        $display("%0d results compared, %0d with a button down, %0d mismatches",
                 checked, button_down, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
